// ===== rtl/vpw_pkg.sv =====
package vpw_pkg;

    localparam int COORD_W = 32;
    localparam int COEF_W  = 16;
    localparam int CLIP_W  = 52;
    localparam int WIN_W   = 14;
    localparam int POS_W   = 23;
    localparam int DEPTH_W = 16;
    localparam int IDX_W   = 24;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_W  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_W  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_H  = 3'd5;

    localparam logic [WIN_W-1:0] WIN_W_RESET = 14'd640;
    localparam logic [WIN_W-1:0] WIN_H_RESET = 14'd480;
    localparam logic [POS_W-1:0] POS_MAX = 23'h7FFFFF;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'hFFFF;

    // Quotient bits produced per divider stage.
    localparam int DIV_BITS = 4;

endpackage

// ===== rtl/vpw_if.sv =====
interface vpw_in_if;
    import vpw_pkg::*;
    logic valid;
    logic ready;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [IDX_W-1:0] vertex_index;
    modport source (output valid, coord_x, coord_y, coord_z, vertex_index, input ready);
    modport sink (input valid, coord_x, coord_y, coord_z, vertex_index, output ready);
endinterface

interface vpw_out_if;
    import vpw_pkg::*;
    logic valid;
    logic ready;
    logic [POS_W-1:0] win_x;
    logic [POS_W-1:0] win_y;
    logic [DEPTH_W-1:0] depth_value;
    logic [IDX_W-1:0] out_index;
    modport source (output valid, win_x, win_y, depth_value, out_index, input ready);
    modport sink (input valid, win_x, win_y, depth_value, out_index, output ready);
endinterface

// ===== rtl/vpw_divider.sv =====
// Pipelined unsigned restoring divider: Q bits of quotient of num / den,
// where num < den * 2^Q is guaranteed by the caller. DIV_BITS quotient bits per stage.
module vpw_divider
    import vpw_pkg::*;
#(
    parameter int NUM_W = 80,
    parameter int DEN_W = 52,
    parameter int Q_W   = 24,
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic [Q_W-1:0]   o_quot,
    output logic [TAG_W-1:0] o_tag
);
    localparam int STAGES = (Q_W + DIV_BITS - 1) / DIV_BITS;
    localparam int QP_W   = STAGES * DIV_BITS;
    localparam int REM_W  = DEN_W + 1;

    // Per stage: partial remainder, remaining low numerator bits, quotient.
    logic [REM_W-1:0] r_rem  [STAGES+1];
    logic [QP_W-1:0]  r_low  [STAGES+1];
    logic [QP_W-1:0]  r_quot [STAGES+1];
    logic [DEN_W-1:0] r_den  [STAGES+1];
    logic [TAG_W-1:0] r_tag  [STAGES+1];

    // The top part of num is below den, so it is the starting remainder.
    always_comb begin
        r_rem[0]  = REM_W'(i_num >> Q_W);
        r_low[0]  = QP_W'(i_num[Q_W-1:0]) << (QP_W - Q_W);
        r_quot[0] = '0;
        r_den[0]  = i_den;
        r_tag[0]  = i_tag;
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [REM_W-1:0] n_rem;
        logic [QP_W-1:0]  n_low;
        logic [QP_W-1:0]  n_quot;
        always_comb begin
            logic [REM_W:0] trial;
            n_rem  = r_rem[s];
            n_low  = r_low[s];
            n_quot = r_quot[s];
            for (int b = 0; b < DIV_BITS; b++) begin
                trial = {n_rem, n_low[QP_W-1]} - {2'b00, r_den[s]};
                if (!trial[REM_W]) begin
                    n_rem = trial[REM_W-1:0];
                    n_quot = {n_quot[QP_W-2:0], 1'b1};
                end else begin
                    n_rem = {n_rem[REM_W-2:0], n_low[QP_W-1]};
                    n_quot = {n_quot[QP_W-2:0], 1'b0};
                end
                n_low = {n_low[QP_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= n_rem;
                r_low[s+1]  <= n_low;
                r_quot[s+1] <= n_quot;
                r_den[s+1]  <= r_den[s];
                r_tag[s+1]  <= r_tag[s];
            end
        end
    end

    assign o_quot = r_quot[STAGES][Q_W-1:0];
    assign o_tag  = r_tag[STAGES];
endmodule

// ===== rtl/vertex_project_to_window_unit.sv =====
// Vertex projection to window coordinates.
//
// Channels: s_in carries one vertex word (coord_x/y/z in Q16.16 and an index);
// m_out carries one projected word (win_x, win_y, depth_value, out_index).
// A vertex whose clip w is zero, or that falls outside the open window
// rectangle, produces no output word.
// The user must only write the four matrix rows and the window size through the
// configuration port while the block is idle; the block does not enforce it.
//
// Throughput: one vertex per cycle while the receiver does not stall. The
// pipeline is six arithmetic stages (multiply, sum, sign fix, window scale,
// bound multiply, compare), the six stage divider that makes 24 quotient
// bits, four per stage, for each coordinate, and the output register.
//
// Reset clears the non-divider valid bits and loads the register reset values.
// When the receiver stalls, the whole pipeline holds; a word waiting at
// the output is held stable until taken, and s_in.ready drops.
module vertex_project_to_window_unit
    import vpw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    vpw_in_if.sink               s_in,
    vpw_out_if.source            m_out
);
    localparam int DIV_Q = 24;
    localparam int NUM_W = CLIP_W + WIN_W + DIV_Q;

    // Configuration registers.
    logic [CFG_W-1:0] r_row [4];
    logic [WIN_W-1:0] r_win_w, r_win_h;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_row[i] <= '0;
            r_win_w <= WIN_W_RESET;
            r_win_h <= WIN_H_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROW_X: r_row[0] <= i_cfg_data;
                REG_ROW_Y: r_row[1] <= i_cfg_data;
                REG_ROW_Z: r_row[2] <= i_cfg_data;
                REG_ROW_W: r_row[3] <= i_cfg_data;
                REG_WIN_W: r_win_w <= i_cfg_data[WIN_W-1:0];
                REG_WIN_H: r_win_h <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Global stall: everything advances when the output slot is free.
    logic w_en;
    logic r_out_valid;
    assign w_en = !r_out_valid || m_out.ready;
    assign s_in.ready = w_en;

    // Stage 1: twelve products.
    logic r_v1;
    logic signed [47:0] r_p [4][3];
    logic signed [COEF_W-1:0] r_c3 [4];
    logic [IDX_W-1:0] r_idx1;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_p[k][0] <= s_in.coord_x * $signed(r_row[k][15:0]);
                r_p[k][1] <= s_in.coord_y * $signed(r_row[k][31:16]);
                r_p[k][2] <= s_in.coord_z * $signed(r_row[k][47:32]);
                r_c3[k] <= $signed(r_row[k][63:48]);
            end
            r_idx1 <= s_in.vertex_index;
        end
    end

    // Stage 2: clip sums; the sign normalization to positive w follows in stage 3.
    logic r_v2;
    logic signed [CLIP_W-1:0] r_clip [4];
    logic [IDX_W-1:0] r_idx2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_clip[k] <= CLIP_W'(r_p[k][0]) + CLIP_W'(r_p[k][1]) + CLIP_W'(r_p[k][2])
                           + (CLIP_W'(r_c3[k]) <<< 16);
            end
            r_idx2 <= r_idx1;
        end
    end

    logic r_v3, r_wz3;
    logic signed [CLIP_W:0] r_n3 [3];
    logic [CLIP_W-1:0] r_den3;
    logic [IDX_W-1:0] r_idx3;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            logic neg;
            neg = r_clip[3][CLIP_W-1];
            r_wz3 <= (r_clip[3] == '0);
            r_den3 <= neg ? CLIP_W'(-r_clip[3]) : CLIP_W'(r_clip[3]);
            // Numerators den + c for x, y and z, with c negated along with a negative w.
            for (int k = 0; k < 3; k++) begin
                r_n3[k] <= neg ? -($signed({r_clip[3][CLIP_W-1], r_clip[3]})
                                   + $signed({r_clip[k][CLIP_W-1], r_clip[k]}))
                               : $signed({r_clip[3][CLIP_W-1], r_clip[3]})
                                   + $signed({r_clip[k][CLIP_W-1], r_clip[k]});
            end
            r_idx3 <= r_idx2;
        end
    end

    // Stage 4: x and y numerators scaled by half the window size.
    logic r_v4, r_wz4;
    logic signed [CLIP_W+WIN_W+1:0] r_num4 [2];
    logic signed [CLIP_W:0] r_nz4;
    logic [CLIP_W-1:0] r_den4;
    logic [WIN_W-1:0] r_bw4, r_bh4;
    logic [IDX_W-1:0] r_idx4;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num4[0] <= r_n3[0] * $signed({2'b00, r_win_w[WIN_W-1:1]});
            r_num4[1] <= r_n3[1] * $signed({2'b00, r_win_h[WIN_W-1:1]});
            r_nz4 <= r_n3[2];
            r_den4 <= r_den3;
            r_wz4 <= r_wz3;
            r_bw4 <= r_win_w - 1'b1;
            r_bh4 <= r_win_h - 1'b1;
            r_idx4 <= r_idx3;
        end
    end

    // Stage 5: bound products for the strict window test. A zero-sized
    // window gives a zero numerator, so the positive test rejects it.
    logic r_v5, r_ok5;
    logic [CLIP_W+WIN_W-1:0] r_num5 [2];
    logic [CLIP_W-1:0] r_den5;
    logic [CLIP_W:0] r_nz5;
    logic r_zlo5, r_zhi5;
    logic [CLIP_W+WIN_W-1:0] r_bx5, r_by5;
    logic [IDX_W-1:0] r_idx5;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bx5 <= r_den4 * r_bw4;
            r_by5 <= r_den4 * r_bh4;
            r_ok5 <= !r_wz4 && r_bw4 != '0 && r_bh4 != '0
                     && r_num4[0] > 0 && r_num4[1] > 0;
            r_num5[0] <= r_num4[0][CLIP_W+WIN_W-1:0];
            r_num5[1] <= r_num4[1][CLIP_W+WIN_W-1:0];
            r_zlo5 <= (r_nz4 <= 0);
            r_zhi5 <= (r_nz4 >= $signed({r_den4, 1'b0}));
            r_nz5 <= r_nz4;
            r_den5 <= r_den4;
            r_idx5 <= r_idx4;
        end
    end

    // Stage 6: window compare, divider inputs.
    logic r_v6, r_ok6, r_zlo6, r_zhi6;
    logic [NUM_W-1:0] r_dn6 [3];
    logic [CLIP_W-1:0] r_den6;
    logic [IDX_W-1:0] r_idx6;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ok6 <= r_ok5 && r_num5[0] < r_bx5 && r_num5[1] < r_by5;
            // Quotient scaled by 2^10 for positions, 2^15 for depth.
            r_dn6[0] <= NUM_W'(r_num5[0]) << 10;
            r_dn6[1] <= NUM_W'(r_num5[1]) << 10;
            r_dn6[2] <= (r_zlo5 || r_zhi5) ? '0 : NUM_W'(r_nz5[CLIP_W:0]) << 15;
            r_zlo6 <= r_zlo5;
            r_zhi6 <= r_zhi5;
            r_den6 <= r_den5;
            r_idx6 <= r_idx5;
        end
    end

    // Divider stages: one divider per coordinate; the quotient fits for every vertex that passes the window test.
    logic [DIV_Q-1:0] w_q [3];
    logic [IDX_W+3-1:0] w_tag;
    vpw_divider #(.NUM_W(NUM_W), .DEN_W(CLIP_W), .Q_W(DIV_Q), .TAG_W(IDX_W+3)) u_div_x (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_dn6[0]), .i_den(r_den6),
        .i_tag({r_idx6, r_ok6 & r_v6, r_zlo6, r_zhi6}), .o_quot(w_q[0]), .o_tag(w_tag)
    );
    for (genvar k = 1; k < 3; k++) begin : g_div
        logic [0:0] w_unused;
        vpw_divider #(.NUM_W(NUM_W), .DEN_W(CLIP_W), .Q_W(DIV_Q), .TAG_W(1)) u_div (
            .i_clk(i_clk), .i_en(w_en), .i_num(r_dn6[k]), .i_den(r_den6),
            .i_tag(1'b0), .o_quot(w_q[k]), .o_tag(w_unused)
        );
    end

    // Valid chain for stages 1 to 6.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_v4 <= 1'b0; r_v5 <= 1'b0; r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= s_in.valid; r_v2 <= r_v1; r_v3 <= r_v2;
            r_v4 <= r_v3; r_v5 <= r_v4; r_v6 <= r_v5;
        end
    end

    // The divider's valid travels in its tag; a reset flush counter masks
    // stale tags until the divider has been filled after reset.
    localparam int FLUSH = (DIV_Q + DIV_BITS - 1) / DIV_BITS;
    logic [3:0] r_flush;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_flush <= 4'(FLUSH);
        else if (w_en && r_flush != '0) r_flush <= r_flush - 1'b1;
    end

    // Output register with saturation.
    logic [POS_W-1:0] r_wx, r_wy;
    logic [DEPTH_W-1:0] r_dv;
    logic [IDX_W-1:0] r_oidx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_tag[2] && r_flush == '0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wx <= (w_q[0] > DIV_Q'(POS_MAX)) ? POS_MAX : w_q[0][POS_W-1:0];
            r_wy <= (w_q[1] > DIV_Q'(POS_MAX)) ? POS_MAX : w_q[1][POS_W-1:0];
            if (w_tag[1]) r_dv <= '0;
            else if (w_tag[0] || w_q[2] > DIV_Q'(DEPTH_MAX)) r_dv <= DEPTH_MAX;
            else r_dv <= w_q[2][DEPTH_W-1:0];
            r_oidx <= w_tag[IDX_W+2:3];
        end
    end

    assign m_out.valid = r_out_valid;
    assign m_out.win_x = r_wx;
    assign m_out.win_y = r_wy;
    assign m_out.depth_value = r_dv;
    assign m_out.out_index = r_oidx;
endmodule
